// File: rtl/sdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sdp_pkg;

    // Result field codes
    localparam logic [4:0] CODE_IDENTIFIER   = 5'd0;
    localparam logic [4:0] CODE_EVENT_ID     = 5'd1;
    localparam logic [4:0] CODE_CANCEL       = 5'd2;
    localparam logic [4:0] CODE_PROGRAM_SEG  = 5'd3;
    localparam logic [4:0] CODE_COUNT        = 5'd9;
    localparam logic [4:0] CODE_TAG          = 5'd10;
    localparam logic [4:0] CODE_PTS          = 5'd11;
    localparam logic [4:0] CODE_DURATION     = 5'd12;
    localparam logic [4:0] CODE_UPID_TYPE    = 5'd13;
    localparam logic [4:0] CODE_UPID_LENGTH  = 5'd14;
    localparam logic [4:0] CODE_UPID_BYTE    = 5'd15;
    localparam logic [4:0] CODE_TYPE_ID      = 5'd16;
    localparam logic [4:0] CODE_SEG_NUM      = 5'd17;
    localparam logic [4:0] CODE_SEG_EXPECTED = 5'd18;
    localparam logic [4:0] CODE_SUB_NUM      = 5'd19;
    localparam logic [4:0] CODE_SUB_EXPECTED = 5'd20;
    localparam logic [4:0] CODE_CLASS        = 5'd21;
    localparam logic [4:0] CODE_END          = 5'd22;

    // End status codes
    localparam logic [1:0] END_COMPLETE  = 2'd0;
    localparam logic [1:0] END_TRUNCATED = 2'd1;
    localparam logic [1:0] END_TRAILING  = 2'd2;

    // Class codes
    localparam logic [1:0] CLASS_NEITHER = 2'd0;
    localparam logic [1:0] CLASS_OUT     = 2'd1;
    localparam logic [1:0] CLASS_IN      = 2'd2;

    // Flag byte results come out as one group of this many
    localparam logic [2:0] FLAG_RESULTS = 3'd6;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  field_code;
        logic [39:0] field_value;
        logic [7:0]  item_index;
        logic [1:0]  end_status;
        logic        run_last;
    } out_item_t;

    // What one accepted byte asks the back end to emit
    typedef enum logic [1:0] {
        JK_NONE  = 2'd0,   // end result only
        JK_ONE   = 2'd1,   // one field result
        JK_FLAGS = 2'd2,   // six flag results, packed in value[6:0]
        JK_TYPE  = 2'd3    // type id then class
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [4:0]  code;
        logic [39:0] value;
        logic [7:0]  index;
        logic        has_end;
        logic [1:0]  end_status;
    } job_t;

    function automatic logic [1:0] class_of(input logic [7:0] t);
        logic [1:0] c;
        unique case (t) inside
            8'h10, 8'h14, 8'h17, 8'h19, 8'h20, 8'h22,
            8'h30, 8'h32, 8'h34, 8'h36, 8'h40, 8'h50: c = CLASS_OUT;
            8'h11, 8'h12, 8'h13, 8'h15, 8'h16, 8'h18,
            8'h21, 8'h23, 8'h31, 8'h33, 8'h35, 8'h37,
            8'h41, 8'h51:                             c = CLASS_IN;
            default:                                  c = CLASS_NEITHER;
        endcase
        return c;
    endfunction

    function automatic logic has_sub_segments(input logic [7:0] t);
        return (t == 8'h34) || (t == 8'h36) || (t == 8'h38) || (t == 8'h3A);
    endfunction

endpackage
`default_nettype wire

// File: rtl/sdp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sdp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sdp_pkg::job_t push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output sdp_pkg::job_t      head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sdp_pkg::job_t  mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/sdp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sdp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_ready,
    input  wire sdp_pkg::in_item_t byte_data,
    output logic                   job_push,
    output sdp_pkg::job_t          job_data,
    input  wire logic              queue_full
);

    typedef enum logic [16:0] {
        PH_ID        = 17'h00001,
        PH_EVENT     = 17'h00002,
        PH_CANCEL    = 17'h00004,
        PH_FLAGS     = 17'h00008,
        PH_COUNT     = 17'h00010,
        PH_TAG       = 17'h00020,
        PH_PTS       = 17'h00040,
        PH_DUR       = 17'h00080,
        PH_UPID_TYPE = 17'h00100,
        PH_UPID_LEN  = 17'h00200,
        PH_UPID_DATA = 17'h00400,
        PH_TYPE_ID   = 17'h00800,
        PH_SEG_NUM   = 17'h01000,
        PH_SEG_EXP   = 17'h02000,
        PH_SUB_NUM   = 17'h04000,
        PH_SUB_EXP   = 17'h08000,
        PH_DONE      = 17'h10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  byte_cnt_reg, byte_cnt_next;
    logic [39:0] acc_reg, acc_next;
    logic [7:0]  comp_left_reg, comp_left_next;
    logic [7:0]  comp_pos_reg, comp_pos_next;
    logic [7:0]  upid_left_reg, upid_left_next;
    logic [7:0]  upid_pos_reg, upid_pos_next;
    logic        dur_reg, dur_next;
    logic [7:0]  type_reg, type_next;

    logic        accept;
    logic [7:0]  b;
    logic [39:0] acc_shift;
    logic        last4, last5;
    logic        web, blk, arc;
    logic [1:0]  dev;
    sdp_pkg::job_t job;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;
    assign b          = byte_data.in_byte;
    assign acc_shift  = {acc_reg[31:0], b};
    assign last4      = (byte_cnt_reg == 3'd3);
    assign last5      = (byte_cnt_reg == 3'd4);

    // not-restricted forces the delivery flags
    assign web = b[5] ? 1'b1  : b[4];
    assign blk = b[5] ? 1'b1  : b[3];
    assign arc = b[5] ? 1'b1  : b[2];
    assign dev = b[5] ? 2'd3  : b[1:0];

    always_comb
    begin
        phase_next     = phase_reg;
        byte_cnt_next  = byte_cnt_reg;
        acc_next       = acc_reg;
        comp_left_next = comp_left_reg;
        comp_pos_next  = comp_pos_reg;
        upid_left_next = upid_left_reg;
        upid_pos_next  = upid_pos_reg;
        dur_next       = dur_reg;
        type_next      = type_reg;

        job            = '0;
        job.kind       = sdp_pkg::JK_NONE;

        unique case (phase_reg)
            PH_ID, PH_EVENT:
            begin
                acc_next      = last4 ? '0 : acc_shift;
                byte_cnt_next = last4 ? 3'd0 : byte_cnt_reg + 3'd1;
                if (last4)
                begin
                    job.kind  = sdp_pkg::JK_ONE;
                    job.code  = (phase_reg == PH_ID) ? sdp_pkg::CODE_IDENTIFIER
                                                     : sdp_pkg::CODE_EVENT_ID;
                    job.value = acc_shift;
                    phase_next = (phase_reg == PH_ID) ? PH_EVENT : PH_CANCEL;
                end
            end
            PH_CANCEL:
            begin
                job.kind   = sdp_pkg::JK_ONE;
                job.code   = sdp_pkg::CODE_CANCEL;
                job.value  = {39'd0, b[7]};
                phase_next = b[7] ? PH_DONE : PH_FLAGS;
            end
            PH_FLAGS:
            begin
                job.kind   = sdp_pkg::JK_FLAGS;
                job.code   = sdp_pkg::CODE_PROGRAM_SEG;
                job.value  = {33'd0, b[7], b[6], web, blk, arc, dev};
                dur_next   = b[6];
                if (!b[7])
                begin
                    phase_next = PH_COUNT;
                end
                else
                begin
                    phase_next = b[6] ? PH_DUR : PH_UPID_TYPE;
                end
            end
            PH_COUNT:
            begin
                job.kind       = sdp_pkg::JK_ONE;
                job.code       = sdp_pkg::CODE_COUNT;
                job.value      = {32'd0, b};
                comp_left_next = b;
                comp_pos_next  = '0;
                if (b != 8'd0)
                begin
                    phase_next = PH_TAG;
                end
                else
                begin
                    phase_next = dur_reg ? PH_DUR : PH_UPID_TYPE;
                end
            end
            PH_TAG:
            begin
                job.kind   = sdp_pkg::JK_ONE;
                job.code   = sdp_pkg::CODE_TAG;
                job.value  = {32'd0, b};
                job.index  = comp_pos_reg;
                phase_next = PH_PTS;
            end
            PH_PTS:
            begin
                acc_next      = last5 ? '0 : acc_shift;
                byte_cnt_next = last5 ? 3'd0 : byte_cnt_reg + 3'd1;
                if (last5)
                begin
                    job.kind       = sdp_pkg::JK_ONE;
                    job.code       = sdp_pkg::CODE_PTS;
                    // reserved bits ahead of the 33-bit offset are dropped
                    job.value      = {7'd0, acc_shift[32:0]};
                    job.index      = comp_pos_reg;
                    comp_pos_next  = comp_pos_reg + 8'd1;
                    comp_left_next = comp_left_reg - 8'd1;
                    if (comp_left_reg == 8'd1)
                    begin
                        phase_next = dur_reg ? PH_DUR : PH_UPID_TYPE;
                    end
                    else
                    begin
                        phase_next = PH_TAG;
                    end
                end
            end
            PH_DUR:
            begin
                acc_next      = last5 ? '0 : acc_shift;
                byte_cnt_next = last5 ? 3'd0 : byte_cnt_reg + 3'd1;
                if (last5)
                begin
                    job.kind   = sdp_pkg::JK_ONE;
                    job.code   = sdp_pkg::CODE_DURATION;
                    job.value  = acc_shift;
                    phase_next = PH_UPID_TYPE;
                end
            end
            PH_UPID_TYPE:
            begin
                job.kind   = sdp_pkg::JK_ONE;
                job.code   = sdp_pkg::CODE_UPID_TYPE;
                job.value  = {32'd0, b};
                phase_next = PH_UPID_LEN;
            end
            PH_UPID_LEN:
            begin
                job.kind       = sdp_pkg::JK_ONE;
                job.code       = sdp_pkg::CODE_UPID_LENGTH;
                job.value      = {32'd0, b};
                upid_left_next = b;
                upid_pos_next  = '0;
                phase_next     = (b == 8'd0) ? PH_TYPE_ID : PH_UPID_DATA;
            end
            PH_UPID_DATA:
            begin
                job.kind       = sdp_pkg::JK_ONE;
                job.code       = sdp_pkg::CODE_UPID_BYTE;
                job.value      = {32'd0, b};
                job.index      = upid_pos_reg;
                upid_pos_next  = upid_pos_reg + 8'd1;
                upid_left_next = upid_left_reg - 8'd1;
                if (upid_left_reg == 8'd1)
                begin
                    phase_next = PH_TYPE_ID;
                end
            end
            PH_TYPE_ID:
            begin
                job.kind   = sdp_pkg::JK_TYPE;
                job.code   = sdp_pkg::CODE_TYPE_ID;
                job.value  = {32'd0, b};
                type_next  = b;
                phase_next = PH_SEG_NUM;
            end
            PH_SEG_NUM:
            begin
                job.kind   = sdp_pkg::JK_ONE;
                job.code   = sdp_pkg::CODE_SEG_NUM;
                job.value  = {32'd0, b};
                phase_next = PH_SEG_EXP;
            end
            PH_SEG_EXP:
            begin
                job.kind   = sdp_pkg::JK_ONE;
                job.code   = sdp_pkg::CODE_SEG_EXPECTED;
                job.value  = {32'd0, b};
                phase_next = sdp_pkg::has_sub_segments(type_reg) ? PH_SUB_NUM : PH_DONE;
            end
            PH_SUB_NUM:
            begin
                job.kind   = sdp_pkg::JK_ONE;
                job.code   = sdp_pkg::CODE_SUB_NUM;
                job.value  = {32'd0, b};
                phase_next = PH_SUB_EXP;
            end
            PH_SUB_EXP:
            begin
                job.kind   = sdp_pkg::JK_ONE;
                job.code   = sdp_pkg::CODE_SUB_EXPECTED;
                job.value  = {32'd0, b};
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // last byte: end status, then back to the start for the next descriptor
        if (byte_data.final_byte)
        begin
            job.has_end = 1'b1;
            if (phase_reg == PH_DONE)
            begin
                job.end_status = sdp_pkg::END_TRAILING;
            end
            else if (phase_next == PH_DONE)
            begin
                job.end_status = sdp_pkg::END_COMPLETE;
            end
            else
            begin
                job.end_status = sdp_pkg::END_TRUNCATED;
            end
            phase_next     = PH_ID;
            byte_cnt_next  = '0;
            acc_next       = '0;
            comp_left_next = '0;
            comp_pos_next  = '0;
            upid_left_next = '0;
            upid_pos_next  = '0;
            dur_next       = 1'b0;
            type_next      = '0;
        end
    end

    assign job_data = job;
    assign job_push = accept && ((job.kind != sdp_pkg::JK_NONE) || job.has_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ID;
            byte_cnt_reg  <= '0;
            acc_reg       <= '0;
            comp_left_reg <= '0;
            comp_pos_reg  <= '0;
            upid_left_reg <= '0;
            upid_pos_reg  <= '0;
            dur_reg       <= 1'b0;
            type_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            byte_cnt_reg  <= byte_cnt_next;
            acc_reg       <= acc_next;
            comp_left_reg <= comp_left_next;
            comp_pos_reg  <= comp_pos_next;
            upid_left_reg <= upid_left_next;
            upid_pos_reg  <= upid_pos_next;
            dur_reg       <= dur_next;
            type_reg      <= type_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/sdp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sdp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire sdp_pkg::job_t job,
    output logic               job_pop,
    output logic               result_valid,
    input  wire logic          result_ready,
    output sdp_pkg::out_item_t result_data
);

    logic [2:0]         step_reg, step_next;
    logic               valid_reg, valid_next;
    sdp_pkg::out_item_t out_reg, out_next;

    logic [2:0]         body_cnt;
    logic               load, last_step, end_step;
    sdp_pkg::out_item_t res;

    always_comb
    begin
        unique case (job.kind)
            sdp_pkg::JK_ONE:   body_cnt = 3'd1;
            sdp_pkg::JK_FLAGS: body_cnt = sdp_pkg::FLAG_RESULTS;
            sdp_pkg::JK_TYPE:  body_cnt = 3'd2;
            default:           body_cnt = 3'd0;
        endcase
    end

    assign end_step  = job.has_end && (step_reg == body_cnt);
    assign last_step = job.has_end ? (step_reg == body_cnt) : (step_reg == body_cnt - 3'd1);
    assign load      = job_valid && (!valid_reg || result_ready);
    assign job_pop   = load && last_step;

    always_comb
    begin
        res          = '0;
        res.run_last = last_step;
        if (end_step)
        begin
            res.field_code = sdp_pkg::CODE_END;
            res.end_status = job.end_status;
        end
        else
        begin
            unique case (job.kind)
                sdp_pkg::JK_FLAGS:
                begin
                    res.field_code = job.code + {2'd0, step_reg};
                    case (step_reg)
                        3'd0:    res.field_value = {39'd0, job.value[6]};
                        3'd1:    res.field_value = {39'd0, job.value[5]};
                        3'd2:    res.field_value = {39'd0, job.value[4]};
                        3'd3:    res.field_value = {39'd0, job.value[3]};
                        3'd4:    res.field_value = {39'd0, job.value[2]};
                        default: res.field_value = {38'd0, job.value[1:0]};
                    endcase
                end
                sdp_pkg::JK_TYPE:
                begin
                    if (step_reg == 3'd0)
                    begin
                        res.field_code  = job.code;
                        res.field_value = job.value;
                    end
                    else
                    begin
                        res.field_code  = sdp_pkg::CODE_CLASS;
                        res.field_value = {38'd0, sdp_pkg::class_of(job.value[7:0])};
                    end
                end
                default:
                begin
                    res.field_code  = job.code;
                    res.field_value = job.value;
                    res.item_index  = job.index;
                end
            endcase
        end
    end

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        if (load)
        begin
            out_next   = res;
            valid_next = 1'b1;
            step_next  = last_step ? 3'd0 : step_reg + 3'd1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;
    assign result_data  = out_reg;

`ifndef ASSERT_OFF
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (out_reg.field_code == sdp_pkg::CODE_END)) |-> out_reg.run_last)
        else $error("end result not marked as last of its byte");

    a_status_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (out_reg.end_status != sdp_pkg::END_COMPLETE))
            |-> (out_reg.field_code == sdp_pkg::CODE_END))
        else $error("end status set on a field result");

    a_step_restart: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> (step_reg == 3'd0))
        else $error("step counter not restarted after a request finished");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> (step_reg <= body_cnt))
        else $error("step counter ran past the request");
`endif

endmodule
`default_nettype wire

// File: rtl/segmentation_descriptor_parser.sv
// A byte's request is registered in the queue, and its results in the output register.
// Throughput: one byte per cycle while the queue has room; results leave one per cycle
// while result_ready is high. A flag byte yields six results and the type id two; the
// QUEUE_DEPTH-entry request queue takes the bytes behind them, and byte_ready drops when
// it fills.
// Reset (rst_n, async, active low) empties the queue and output and restarts parsing.
`timescale 1ns / 1ps
`default_nettype none
module segmentation_descriptor_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // payload bytes in
    input  wire logic               byte_valid,
    output logic                    byte_ready,
    input  wire sdp_pkg::in_item_t  byte_data,
    // decoded results out
    output logic                    result_valid,
    input  wire logic               result_ready,
    output sdp_pkg::out_item_t      result_data
);

    // Front end: walks the descriptor layout one byte per cycle while the queue
    // has room, and turns each byte into at most one request for the back end.
    logic          push;
    logic          full;
    sdp_pkg::job_t push_job;

    // Back end: expands one request into its results.
    logic          pop;
    logic          queued;
    sdp_pkg::job_t head_job;

    sdp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .job_push   (push),
        .job_data   (push_job),
        .queue_full (full)
    );

    // Decouples byte intake from result delivery.
    sdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .not_empty (queued),
        .head      (head_job)
    );

    sdp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (queued),
        .job          (head_job),
        .job_pop      (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule
`default_nettype wire

// File: tb/segmentation_descriptor_parser_tb.sv
`timescale 1ns / 1ps
module segmentation_descriptor_parser_tb;

    // Flag byte result codes that the package does not name
    localparam logic [4:0] CODE_HAS_DURATION = 5'd4;
    localparam logic [4:0] CODE_WEB          = 5'd5;
    localparam logic [4:0] CODE_BLACKOUT     = 5'd6;
    localparam logic [4:0] CODE_ARCHIVE      = 5'd7;
    localparam logic [4:0] CODE_DEVICE       = 5'd8;

    localparam int RANDOM_ITEMS = 80;
    localparam int HOLD_OFF     = 150;   // long receiver stall, fills the request queue
    localparam int DRAIN_CYCLES = 30;

    // Where the decoder sits inside one descriptor
    typedef enum logic [4:0] {
        P_IDENT, P_EVENT, P_CANCEL, P_FLAGS, P_COUNT, P_TAG, P_PTS, P_DURATION,
        P_UPID_TYPE, P_UPID_LEN, P_UPID_DATA, P_TYPE_ID, P_SEG_NUM, P_SEG_EXP,
        P_SUB_NUM, P_SUB_EXP, P_DONE
    } phase_t;

    // One row of the directed script; code/value/status only mean something when known
    typedef struct {
        logic [7:0]  b;
        logic        fin;
        bit          known;
        logic [4:0]  code;
        logic [39:0] value;
        logic [1:0]  status;
    } script_row_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                byte_valid   = 1'b0;
    logic                result_ready = 1'b0;
    sdp_pkg::in_item_t   byte_data    = '0;
    logic                byte_ready;
    logic                result_valid;
    sdp_pkg::out_item_t  result_data;

    // Decoder state, tracks what the block should be doing
    phase_t      dec_phase     = P_IDENT;
    logic [2:0]  dec_nbyte     = '0;
    logic [39:0] dec_acc       = '0;
    logic [7:0]  dec_comp_left = '0;
    logic [7:0]  dec_comp_pos  = '0;
    logic [7:0]  dec_upid_left = '0;
    logic [7:0]  dec_upid_pos  = '0;
    logic        dec_cancel    = 1'b0;
    logic        dec_prog_wide = 1'b0;
    logic        dec_dur       = 1'b0;
    logic [7:0]  dec_type      = '0;

    sdp_pkg::out_item_t decoded_fields[$];   // results still owed by the block, oldest first
    int          mismatch_count = 0;
    bit          burst = 1'b0;        // sender offers back to back
    bit          hold_off_req = 1'b0; // asks the receiver for one long stall

    logic [7:0]  type_picks [12] = '{8'h10, 8'h11, 8'h22, 8'h23, 8'h34, 8'h35,
                                     8'h36, 8'h37, 8'h38, 8'h3A, 8'h50, 8'h51};

    // Directed script: truncation right after reset, a cancelled event with a
    // trailing byte, then a program-wide, not-restricted event with an empty upid.
    script_row_t script [26] = '{
        '{8'hFF, 1'b1, 1'b1, sdp_pkg::CODE_END,         40'd0,        sdp_pkg::END_TRUNCATED},
        '{8'hFF, 1'b0, 1'b0, '0,                        '0,           '0},
        '{8'hFF, 1'b0, 1'b0, '0,                        '0,           '0},
        '{8'hFF, 1'b0, 1'b0, '0,                        '0,           '0},
        '{8'hFF, 1'b0, 1'b1, sdp_pkg::CODE_IDENTIFIER,  40'hFFFFFFFF, '0},
        '{8'h00, 1'b0, 1'b0, '0,                        '0,           '0},
        '{8'h00, 1'b0, 1'b0, '0,                        '0,           '0},
        '{8'h00, 1'b0, 1'b0, '0,                        '0,           '0},
        '{8'h00, 1'b0, 1'b1, sdp_pkg::CODE_EVENT_ID,    40'd0,        '0},
        '{8'h80, 1'b0, 1'b1, sdp_pkg::CODE_CANCEL,      40'd1,        '0},
        '{8'h00, 1'b1, 1'b1, sdp_pkg::CODE_END,         40'd0,        sdp_pkg::END_TRAILING},
        '{8'h12, 1'b0, 1'b0, '0,                        '0,           '0},
        '{8'h34, 1'b0, 1'b0, '0,                        '0,           '0},
        '{8'h56, 1'b0, 1'b0, '0,                        '0,           '0},
        '{8'h78, 1'b0, 1'b1, sdp_pkg::CODE_IDENTIFIER,  40'h12345678, '0},
        '{8'h80, 1'b0, 1'b0, '0,                        '0,           '0},
        '{8'h00, 1'b0, 1'b0, '0,                        '0,           '0},
        '{8'h00, 1'b0, 1'b0, '0,                        '0,           '0},
        '{8'h01, 1'b0, 1'b1, sdp_pkg::CODE_EVENT_ID,    40'h80000001, '0},
        '{8'h7F, 1'b0, 1'b1, sdp_pkg::CODE_CANCEL,      40'd0,        '0},
        '{8'hA0, 1'b0, 1'b1, CODE_DEVICE,               40'd3,        '0},
        '{8'h00, 1'b0, 1'b1, sdp_pkg::CODE_UPID_TYPE,   40'd0,        '0},
        '{8'h00, 1'b0, 1'b1, sdp_pkg::CODE_UPID_LENGTH, 40'd0,        '0},
        '{8'h10, 1'b0, 1'b1, sdp_pkg::CODE_CLASS,       40'(sdp_pkg::CLASS_OUT), '0},
        '{8'hFF, 1'b0, 1'b1, sdp_pkg::CODE_SEG_NUM,     40'd255,      '0},
        '{8'hFF, 1'b1, 1'b1, sdp_pkg::CODE_END,         40'd0,        sdp_pkg::END_COMPLETE}
    };

    segmentation_descriptor_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Descriptor decoder: turns each accepted byte into owed results
    // ------------------------------------------------------------------

    function automatic void queue_field(input logic [4:0] code, input logic [39:0] value,
                                        input logic [7:0] idx, input logic [1:0] status);
        sdp_pkg::out_item_t r;
        r.field_code  = code;
        r.field_value = value;
        r.item_index  = idx;
        r.end_status  = status;
        r.run_last    = 1'b0;
        decoded_fields.push_back(r);
    endfunction

    // Shift one byte into a multi-byte field; true once the field is whole
    function automatic bit gather(input logic [7:0] b, input int unsigned len);
        dec_acc = {dec_acc[31:0], b};
        if (dec_nbyte + 1 >= len)
        begin
            dec_nbyte = '0;
            return 1'b1;
        end
        dec_nbyte = dec_nbyte + 3'd1;
        return 1'b0;
    endfunction

    function automatic logic [39:0] take_acc();
        logic [39:0] v;
        v = dec_acc;
        dec_acc = '0;
        return v;
    endfunction

    // Duration is optional, upid is always next after it
    function automatic phase_t past_list();
        return dec_dur ? P_DURATION : P_UPID_TYPE;
    endfunction

    function automatic void clear_decoder();
        dec_phase     = P_IDENT;
        dec_nbyte     = '0;
        dec_acc       = '0;
        dec_comp_left = '0;
        dec_comp_pos  = '0;
        dec_upid_left = '0;
        dec_upid_pos  = '0;
        dec_cancel    = 1'b0;
        dec_prog_wide = 1'b0;
        dec_dur       = 1'b0;
        dec_type      = '0;
    endfunction

    function automatic void decode_byte(input sdp_pkg::in_item_t it);
        logic [7:0]         b;
        bit                 was_done;
        int                 first;
        logic               f_web, f_blk, f_arc;
        logic [1:0]         f_dev;
        logic [1:0]         cls;
        logic [1:0]         status;
        sdp_pkg::out_item_t tail;
        b        = it.in_byte;
        was_done = (dec_phase == P_DONE);
        first    = decoded_fields.size();
        case (dec_phase)
            P_IDENT:
            begin
                if (gather(b, 4))
                begin
                    queue_field(sdp_pkg::CODE_IDENTIFIER, take_acc(), '0, '0);
                    dec_phase = P_EVENT;
                end
            end
            P_EVENT:
            begin
                if (gather(b, 4))
                begin
                    queue_field(sdp_pkg::CODE_EVENT_ID, take_acc(), '0, '0);
                    dec_phase = P_CANCEL;
                end
            end
            P_CANCEL:
            begin
                dec_cancel = b[7];
                queue_field(sdp_pkg::CODE_CANCEL, 40'(dec_cancel), '0, '0);
                dec_phase = dec_cancel ? P_DONE : P_FLAGS;
            end
            P_FLAGS:
            begin
                // not-restricted forces all delivery flags on
                f_web = 1'b1;
                f_blk = 1'b1;
                f_arc = 1'b1;
                f_dev = 2'd3;
                dec_prog_wide = b[7];
                dec_dur       = b[6];
                if (!b[5])
                begin
                    f_web = b[4];
                    f_blk = b[3];
                    f_arc = b[2];
                    f_dev = b[1:0];
                end
                queue_field(sdp_pkg::CODE_PROGRAM_SEG, 40'(dec_prog_wide), '0, '0);
                queue_field(CODE_HAS_DURATION, 40'(dec_dur), '0, '0);
                queue_field(CODE_WEB, 40'(f_web), '0, '0);
                queue_field(CODE_BLACKOUT, 40'(f_blk), '0, '0);
                queue_field(CODE_ARCHIVE, 40'(f_arc), '0, '0);
                queue_field(CODE_DEVICE, 40'(f_dev), '0, '0);
                dec_phase = dec_prog_wide ? past_list() : P_COUNT;
            end
            P_COUNT:
            begin
                queue_field(sdp_pkg::CODE_COUNT, 40'(b), '0, '0);
                dec_comp_left = b;
                dec_comp_pos  = '0;
                dec_phase = (b == 8'd0) ? past_list() : P_TAG;
            end
            P_TAG:
            begin
                queue_field(sdp_pkg::CODE_TAG, 40'(b), dec_comp_pos, '0);
                dec_phase = P_PTS;
            end
            P_PTS:
            begin
                if (gather(b, 5))
                begin
                    // 7 reserved bits in front of the 33-bit offset are dropped
                    queue_field(sdp_pkg::CODE_PTS, take_acc() & 40'h1_FFFF_FFFF,
                                dec_comp_pos, '0);
                    dec_comp_pos  = dec_comp_pos + 8'd1;
                    dec_comp_left = dec_comp_left - 8'd1;
                    dec_phase = (dec_comp_left == 8'd0) ? past_list() : P_TAG;
                end
            end
            P_DURATION:
            begin
                if (gather(b, 5))
                begin
                    queue_field(sdp_pkg::CODE_DURATION, take_acc(), '0, '0);
                    dec_phase = P_UPID_TYPE;
                end
            end
            P_UPID_TYPE:
            begin
                queue_field(sdp_pkg::CODE_UPID_TYPE, 40'(b), '0, '0);
                dec_phase = P_UPID_LEN;
            end
            P_UPID_LEN:
            begin
                queue_field(sdp_pkg::CODE_UPID_LENGTH, 40'(b), '0, '0);
                dec_upid_left = b;
                dec_upid_pos  = '0;
                dec_phase = (b == 8'd0) ? P_TYPE_ID : P_UPID_DATA;
            end
            P_UPID_DATA:
            begin
                queue_field(sdp_pkg::CODE_UPID_BYTE, 40'(b), dec_upid_pos, '0);
                dec_upid_pos  = dec_upid_pos + 8'd1;
                dec_upid_left = dec_upid_left - 8'd1;
                if (dec_upid_left == 8'd0)
                    dec_phase = P_TYPE_ID;
            end
            P_TYPE_ID:
            begin
                dec_type = b;
                case (b)
                    8'h10, 8'h14, 8'h17, 8'h19, 8'h20, 8'h22,
                    8'h30, 8'h32, 8'h34, 8'h36, 8'h40, 8'h50:
                        cls = sdp_pkg::CLASS_OUT;
                    8'h11, 8'h12, 8'h13, 8'h15, 8'h16, 8'h18,
                    8'h21, 8'h23, 8'h31, 8'h33, 8'h35, 8'h37,
                    8'h41, 8'h51:
                        cls = sdp_pkg::CLASS_IN;
                    default:
                        cls = sdp_pkg::CLASS_NEITHER;
                endcase
                queue_field(sdp_pkg::CODE_TYPE_ID, 40'(b), '0, '0);
                queue_field(sdp_pkg::CODE_CLASS, 40'(cls), '0, '0);
                dec_phase = P_SEG_NUM;
            end
            P_SEG_NUM:
            begin
                queue_field(sdp_pkg::CODE_SEG_NUM, 40'(b), '0, '0);
                dec_phase = P_SEG_EXP;
            end
            P_SEG_EXP:
            begin
                queue_field(sdp_pkg::CODE_SEG_EXPECTED, 40'(b), '0, '0);
                // only these type ids carry sub-segment numbers
                if (dec_type == 8'h34 || dec_type == 8'h36 ||
                    dec_type == 8'h38 || dec_type == 8'h3A)
                    dec_phase = P_SUB_NUM;
                else
                    dec_phase = P_DONE;
            end
            P_SUB_NUM:
            begin
                queue_field(sdp_pkg::CODE_SUB_NUM, 40'(b), '0, '0);
                dec_phase = P_SUB_EXP;
            end
            P_SUB_EXP:
            begin
                queue_field(sdp_pkg::CODE_SUB_EXPECTED, 40'(b), '0, '0);
                dec_phase = P_DONE;
            end
            default:
                dec_phase = P_DONE;   // trailing bytes: nothing to report
        endcase

        if (it.final_byte)
        begin
            if (was_done)
                status = sdp_pkg::END_TRAILING;
            else if (dec_phase == P_DONE)
                status = sdp_pkg::END_COMPLETE;
            else
                status = sdp_pkg::END_TRUNCATED;
            queue_field(sdp_pkg::CODE_END, '0, '0, status);
            clear_decoder();
        end

        if (decoded_fields.size() > first)
        begin
            tail = decoded_fields[decoded_fields.size() - 1];
            tail.run_last = 1'b1;
            decoded_fields[decoded_fields.size() - 1] = tail;
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one request and wait for it to be taken. Valid is only dropped
    // when a gap follows, so back-to-back requests keep it high.
    task automatic offer(input sdp_pkg::in_item_t it, input bit known,
                         input sdp_pkg::out_item_t known_res);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= it;
        @(posedge clk);
        while (!byte_ready) @(posedge clk);
        decode_byte(it);
        // hand-written expectation stands in for the last result of this byte
        if (known)
            decoded_fields[decoded_fields.size() - 1] = known_res;
    endtask

    // One random descriptor: mostly well formed, some truncated, some with
    // trailing bytes, a few pure noise.
    task automatic make_descriptor(ref sdp_pkg::in_item_t frame[$]);
        logic [7:0]        raw[$];
        logic [7:0]        flags;
        logic [7:0]        tid;
        sdp_pkg::in_item_t it;
        int                n, shape, cut;
        raw.delete();
        frame.delete();
        repeat (8) raw.push_back(8'($urandom));
        // cancel bit set now and then
        raw.push_back({($urandom_range(0, 99) < 15), 7'($urandom)});
        if (!raw[8][7])
        begin
            flags = 8'($urandom);
            raw.push_back(flags);
            if (!flags[7])
            begin
                // small lists mostly; the odd huge count gets cut short below
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
                raw.push_back(8'(n));
                repeat (n * 6) raw.push_back(8'($urandom));
            end
            if (flags[6])
                repeat (5) raw.push_back(8'($urandom));
            raw.push_back(8'($urandom));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
            raw.push_back(8'(n));
            repeat (n) raw.push_back(8'($urandom));
            tid = ($urandom_range(0, 1) == 1) ? type_picks[$urandom_range(0, 11)]
                                              : 8'($urandom);
            raw.push_back(tid);
            repeat (2) raw.push_back(8'($urandom));
            if (tid == 8'h34 || tid == 8'h36 || tid == 8'h38 || tid == 8'h3A)
                repeat (2) raw.push_back(8'($urandom));
        end

        shape = $urandom_range(0, 99);
        if (shape < 8)
        begin
            raw.delete();
            repeat ($urandom_range(1, 8)) raw.push_back(8'($urandom));
        end
        else if (shape < 25 || raw.size() > 48)
        begin
            cut = $urandom_range(1, (raw.size() > 48) ? 48 : raw.size() - 1);
            raw = raw[0:cut-1];
        end
        else if (shape < 40)
        begin
            repeat ($urandom_range(1, 3)) raw.push_back(8'($urandom));
        end

        foreach (raw[i])
        begin
            it.in_byte    = raw[i];
            it.final_byte = (i == raw.size() - 1);
            frame.push_back(it);
        end
    endtask

    initial
    begin : stimulus
        sdp_pkg::in_item_t  it;
        sdp_pkg::out_item_t want;
        sdp_pkg::in_item_t  frame[$];
        int                 sent;
        clear_decoder();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed script
        foreach (script[i])
        begin
            it.in_byte       = script[i].b;
            it.final_byte    = script[i].fin;
            want.field_code  = script[i].code;
            want.field_value = script[i].value;
            want.item_index  = '0;
            want.end_status  = script[i].status;
            want.run_last    = 1'b1;
            offer(it, script[i].known, want);
        end

        // random descriptors; the first goes back to back into a long
        // receiver stall so the block backs up and drops byte_ready
        hold_off_req = 1'b1;
        burst = 1'b1;
        sent = 0;
        want = '0;
        while (sent < RANDOM_ITEMS)
        begin
            make_descriptor(frame);
            foreach (frame[i])
                offer(frame[i], 1'b0, want);
            sent += frame.size();
            burst = ($urandom_range(0, 3) == 0);
        end
        byte_valid <= 1'b0;

        while (decoded_fields.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && decoded_fields.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random backpressure in stretches, plus one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int  hold;
        int  mode_left;
        int  r;
        bit  eager;
        hold = 0;
        mode_left = 0;
        eager = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                eager = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold = HOLD_OFF;
            end
            if (hold > 0)
            begin
                hold--;
                result_ready <= 1'b0;
            end
            else if (eager)
            begin
                result_ready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    hold = $urandom_range(15, 40);
                    result_ready <= 1'b0;
                end
                else
                begin
                    result_ready <= (r >= 30);
                end
            end
        end
    end

    // Compare every taken result with the oldest one owed
    always @(posedge clk)
    begin : result_check
        sdp_pkg::out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (decoded_fields.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: code=%0d value=%h idx=%0d status=%0d last=%0b",
                             result_data.field_code, result_data.field_value,
                             result_data.item_index, result_data.end_status,
                             result_data.run_last);
            end
            else
            begin
                want = decoded_fields.pop_front();
                if (result_data.field_code  !== want.field_code  ||
                    result_data.field_value !== want.field_value ||
                    result_data.item_index  !== want.item_index  ||
                    result_data.end_status  !== want.end_status  ||
                    result_data.run_last    !== want.run_last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch at %0t", $realtime);
                        $display("  exp code=%0d value=%h idx=%0d status=%0d last=%0b",
                                 want.field_code, want.field_value,
                                 want.item_index, want.end_status, want.run_last);
                        $display("  got code=%0d value=%h idx=%0d status=%0d last=%0b",
                                 result_data.field_code, result_data.field_value,
                                 result_data.item_index, result_data.end_status,
                                 result_data.run_last);
                    end
                end
            end
        end
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin : watchdog
        #(10_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
